FILE: rtl/glyph_column_segmenter_defines.svh
// Assertion macros for the glyph column segmenter checker.
// Included by files that hold concurrent assertions; needs clk and rst_n in scope.
`ifndef GLYPH_COLUMN_SEGMENTER_DEFINES_SVH
`define GLYPH_COLUMN_SEGMENTER_DEFINES_SVH

// same-cycle implication, off during reset
`define GCS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcs assertion failed");

// next-cycle implication, off during reset
`define GCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcs assertion failed");

// next-cycle implication, checked through reset as well
`define GCS_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("gcs assertion failed");

`endif

FILE: rtl/gcs_pkg.sv
// Shared types and constants for the glyph column segmenter.
// No dependencies.
`timescale 1ns / 1ps

package gcs_pkg;

    localparam int COLOR_BITS    = 8;
    localparam int SIZE_BITS     = 11;
    localparam int THRESH_BITS   = 9;
    localparam int CFG_DATA_BITS = 11;
    localparam int CFG_IDX_BITS  = 2;
    localparam int BOX_POS_BITS  = 10;
    localparam int BOX_SIZE_BITS = 11;
    localparam int LUMA_BITS     = 24;

    localparam logic [15:0] COEF_RED   = 16'd19595;
    localparam logic [15:0] COEF_GREEN = 16'd38469;
    localparam logic [15:0] COEF_BLUE  = 16'd7472;
    localparam int          LUMA_SHIFT = 16;

    localparam logic [SIZE_BITS-1:0]   WIDTH_RST  = 11'd640;
    localparam logic [SIZE_BITS-1:0]   HEIGHT_RST = 11'd480;
    localparam logic [THRESH_BITS-1:0] THRESH_RST = 9'd128;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_DARK_THRESHOLD = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [BOX_POS_BITS-1:0]  box_left;
        logic [BOX_POS_BITS-1:0]  box_top;
        logic [BOX_SIZE_BITS-1:0] box_width;
        logic [BOX_SIZE_BITS-1:0] box_height;
    } box_t;

endpackage

FILE: rtl/glyph_column_segmenter.sv
// Glyph column segmenter: finds dark glyph bounding boxes by column projection.
// Pixels enter on the pixel channel (valid/stall) in column-major order, one
// request per pixel: rows 0..H-1 of column 0, then column 1, and so on.
// Each pixel is turned to gray and tested against dark_threshold; a running
// box collects ink pixels. At the end of a blank column that follows a column
// with ink, one request carrying the box leaves on the box channel.
// Configuration: cfg_write, cfg_index, cfg_data; write only while idle.
// Index 0 image_width, 1 image_height, 2 dark_threshold; other indexes ignored.
// Throughput: one pixel per clock, set by the single state-update stage, while
// no stalled box blocks it. A box closed by a pixel passes the input register,
// the ink register and the box register before it is shown; box_stall delays it.
// While box_stall holds a pending box, pixels keep filling the two inner
// stages; pixel_stall rises only when both are full.
// Reset clears the counters and valid flags, empties the running box and loads
// 640, 480, 128. State restarts after the last pixel of each image.
`timescale 1ns / 1ps

module glyph_column_segmenter
    import gcs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pixel_valid,
    output logic                     pixel_stall,
    input  pixel_t                   pixel,
    output logic                     box_valid,
    input  logic                     box_stall,
    output box_t                     box,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MW = $clog2(MAX_WIDTH + 1);
    localparam int MH = $clog2(MAX_HEIGHT + 1);
    localparam int EW = (MW + 1 > SIZE_BITS) ? MW + 1 : SIZE_BITS;
    localparam int EH = (MH + 1 > SIZE_BITS) ? MH + 1 : SIZE_BITS;
    localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    logic [SIZE_BITS-1:0]   image_width_reg;
    logic [SIZE_BITS-1:0]   image_height_reg;
    logic [THRESH_BITS-1:0] dark_threshold_reg;

    logic   pix_valid_reg;
    pixel_t pix_reg;
    logic   ink_valid_reg;
    logic   ink_reg;
    logic   box_valid_reg;
    box_t   box_reg;
    logic   ink_comb;

    logic [RW-1:0] row_count_reg, row_count_next;
    logic [CW-1:0] column_count_reg, column_count_next;
    logic [MW-1:0] min_column_reg, min_column_next;
    logic [MH-1:0] min_row_reg, min_row_next;
    logic [CW-1:0] max_column_reg, max_column_next;
    logic [RW-1:0] max_row_reg, max_row_next;
    logic          column_has_ink_reg, column_has_ink_next;
    logic          previous_column_blank_reg, previous_column_blank_next;

    logic          out_free, adv_state, take_ink, pixel_take;
    logic          emit;
    logic          row_last, column_last;
    logic [EW-1:0] width_x, width_eff;
    logic [EH-1:0] height_x, height_eff;
    logic [EW-1:0] min_col_x, box_w_x;
    logic [EH-1:0] min_row_x, box_h_x;
    box_t          box_comb;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= WIDTH_RST;
            image_height_reg   <= HEIGHT_RST;
            dark_threshold_reg <= THRESH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_data;
                CFG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data;
                CFG_DARK_THRESHOLD: dark_threshold_reg <= cfg_data[THRESH_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // clamp sizes to 1..MAX
    always_comb
    begin
        width_x  = EW'(image_width_reg);
        height_x = EH'(image_height_reg);
        priority if (width_x == '0)
            width_eff = EW'(1);
        else if (width_x > EW'(MAX_WIDTH))
            width_eff = EW'(MAX_WIDTH);
        else
            width_eff = width_x;
        priority if (height_x == '0)
            height_eff = EH'(1);
        else if (height_x > EH'(MAX_HEIGHT))
            height_eff = EH'(MAX_HEIGHT);
        else
            height_eff = height_x;
    end

    // handshake
    assign out_free    = !box_valid_reg || !box_stall;
    assign adv_state   = ink_valid_reg && out_free;
    assign take_ink    = pix_valid_reg && (!ink_valid_reg || adv_state);
    assign pixel_stall = pix_valid_reg && !(!ink_valid_reg || adv_state);
    assign pixel_take  = pixel_valid && !pixel_stall;

    gcs_ink u_ink (
        .pixel     (pix_reg),
        .threshold (dark_threshold_reg),
        .ink       (ink_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            ink_valid_reg <= 1'b0;
            box_valid_reg <= 1'b0;
        end
        else
        begin
            if (pixel_take)
                pix_valid_reg <= 1'b1;
            else if (take_ink)
                pix_valid_reg <= 1'b0;

            if (take_ink)
                ink_valid_reg <= 1'b1;
            else if (adv_state)
                ink_valid_reg <= 1'b0;

            if (adv_state)
                box_valid_reg <= emit;
            else if (!box_stall)
                box_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_take)
            pix_reg <= pixel;
        if (take_ink)
            ink_reg <= ink_comb;
        if (adv_state && emit)
            box_reg <= box_comb;
    end

    // box payload from the current box state
    always_comb
    begin
        min_col_x = EW'(min_column_reg);
        min_row_x = EH'(min_row_reg);
        box_w_x   = EW'(max_column_reg) - min_col_x + EW'(1);
        box_h_x   = EH'(max_row_reg) - min_row_x + EH'(1);
        box_comb.box_left   = min_col_x[BOX_POS_BITS-1:0];
        box_comb.box_top    = min_row_x[BOX_POS_BITS-1:0];
        box_comb.box_width  = box_w_x[BOX_SIZE_BITS-1:0];
        box_comb.box_height = box_h_x[BOX_SIZE_BITS-1:0];
    end

    assign row_last    = (EH'(row_count_reg) + EH'(1)) >= height_eff;
    assign column_last = (EW'(column_count_reg) + EW'(1)) >= width_eff;

    always_comb
    begin
        row_count_next             = row_count_reg;
        column_count_next          = column_count_reg;
        min_column_next            = min_column_reg;
        min_row_next               = min_row_reg;
        max_column_next            = max_column_reg;
        max_row_next               = max_row_reg;
        column_has_ink_next        = column_has_ink_reg;
        previous_column_blank_next = previous_column_blank_reg;
        emit                       = 1'b0;

        if (ink_reg)
        begin
            if (MW'(column_count_reg) < min_column_reg)
                min_column_next = MW'(column_count_reg);
            if (MH'(row_count_reg) < min_row_reg)
                min_row_next = MH'(row_count_reg);
            if (column_count_reg > max_column_reg)
                max_column_next = column_count_reg;
            if (row_count_reg > max_row_reg)
                max_row_next = row_count_reg;
            column_has_ink_next = 1'b1;
        end

        if (row_last)
        begin
            if (!column_has_ink_next)
            begin
                if (!previous_column_blank_reg)
                begin
                    emit            = 1'b1;
                    min_column_next = MW'(width_eff);
                    min_row_next    = MH'(height_eff);
                    max_column_next = '0;
                    max_row_next    = '0;
                end
                previous_column_blank_next = 1'b1;
            end
            else
            begin
                previous_column_blank_next = 1'b0;
            end
            column_has_ink_next = 1'b0;
            row_count_next      = '0;
            if (column_last)
            begin
                column_count_next          = '0;
                min_column_next            = MW'(width_eff);
                min_row_next               = MH'(height_eff);
                max_column_next            = '0;
                max_row_next               = '0;
                previous_column_blank_next = 1'b1;
            end
            else
            begin
                column_count_next = column_count_reg + CW'(1);
            end
        end
        else
        begin
            row_count_next = row_count_reg + RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg             <= '0;
            column_count_reg          <= '0;
            min_column_reg            <= MW'(W_RST);
            min_row_reg               <= MH'(H_RST);
            max_column_reg            <= '0;
            max_row_reg               <= '0;
            column_has_ink_reg        <= 1'b0;
            previous_column_blank_reg <= 1'b1;
        end
        else if (adv_state)
        begin
            row_count_reg             <= row_count_next;
            column_count_reg          <= column_count_next;
            min_column_reg            <= min_column_next;
            min_row_reg               <= min_row_next;
            max_column_reg            <= max_column_next;
            max_row_reg               <= max_row_next;
            column_has_ink_reg        <= column_has_ink_next;
            previous_column_blank_reg <= previous_column_blank_next;
        end
    end

    assign box_valid = box_valid_reg;
    assign box       = box_reg;

endmodule

FILE: rtl/gcs_ink.sv
// Gray conversion and ink test for one pixel.
// Depends on gcs_pkg.
`timescale 1ns / 1ps

module gcs_ink
    import gcs_pkg::*;
(
    input  pixel_t                 pixel,
    input  logic [THRESH_BITS-1:0] threshold,
    output logic                   ink
);

    logic [LUMA_BITS-1:0]   luma_sum;
    logic [COLOR_BITS-1:0]  gray;

    assign luma_sum = LUMA_BITS'(pixel.red * COEF_RED)
                    + LUMA_BITS'(pixel.green * COEF_GREEN)
                    + LUMA_BITS'(pixel.blue * COEF_BLUE);
    assign gray = luma_sum[LUMA_SHIFT +: COLOR_BITS];
    assign ink  = ({1'b0, gray} < threshold);

endmodule

FILE: rtl/gcs_checker.sv
// Port-level checks for the glyph column segmenter, bound to the top level.
// Depends on gcs_pkg and glyph_column_segmenter_defines.svh.
`timescale 1ns / 1ps
`include "glyph_column_segmenter_defines.svh"

module gcs_checker
    import gcs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     pixel_valid,
    input logic                     pixel_stall,
    input pixel_t                   pixel,
    input logic                     box_valid,
    input logic                     box_stall,
    input box_t                     box
);

    `GCS_ASSERT_NEXT(a_box_hold, box_valid && box_stall, box_valid && $stable(box))
    `GCS_ASSERT_NEXT(a_pixel_hold, pixel_valid && pixel_stall, pixel_valid && $stable(pixel))
    `GCS_ASSERT_SAME(a_box_nonempty, box_valid, box.box_width != '0 && box.box_height != '0)
    `GCS_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !box_valid && !pixel_stall)

endmodule

bind glyph_column_segmenter gcs_checker u_gcs_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for glyph_column_segmenter: column-major pixel
// requests in, glyph boxes out, checked against an in-bench box predictor.
// Depends on gcs_pkg and the glyph_column_segmenter RTL.
`timescale 1ns / 1ps

module testbench;
    import gcs_pkg::*;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int DRAIN_CYCLES = 16;
    localparam int BOX_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pixel_valid = 1'b0;
    logic pixel_stall;
    pixel_t pixel = '0;
    logic box_valid;
    logic box_stall = 1'b0;
    box_t box;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // predictor configuration and state
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [8:0] thresh_reg;
    logic [9:0] row_pos;
    logic [9:0] col_pos;
    logic [10:0] box_min_col;
    logic [10:0] box_min_row;
    logic [9:0] box_max_col;
    logic [9:0] box_max_row;
    bit col_inked;
    bit prev_col_blank;

    pixel_t pixel_backlog[$];
    box_t box_expect[$];
    box_t due_box;
    int pixels_queued = 0;
    int pixels_accepted = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit pixel_taken = 1'b0;
    bit box_hold = 1'b0;
    bit box_hold_request = 1'b0;

    glyph_column_segmenter DUT (
        .clk(clk),
        .rst_n(rst_n),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel(pixel),
        .box_valid(box_valid),
        .box_stall(box_stall),
        .box(box),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [10:0] clamp_dim(input logic [10:0] v, input int limit);
        if (v == 0)
            return 11'd1;
        if (v > limit)
            return limit[10:0];
        return v;
    endfunction

    task automatic restore_box();
        box_min_col = clamp_dim(width_reg, MAX_COLUMNS);
        box_min_row = clamp_dim(height_reg, MAX_ROWS);
        box_max_col = '0;
        box_max_row = '0;
    endtask

    task automatic restart_image();
        row_pos = '0;
        col_pos = '0;
        restore_box();
        col_inked = 1'b0;
        prev_col_blank = 1'b1;
    endtask

    task automatic segment_pixel(input pixel_t px);
        logic [10:0] w_eff;
        logic [10:0] h_eff;
        int unsigned gray_level;
        box_t found;
        w_eff = clamp_dim(width_reg, MAX_COLUMNS);
        h_eff = clamp_dim(height_reg, MAX_ROWS);
        gray_level = (int'(px.red) * COEF_RED + int'(px.green) * COEF_GREEN
                      + int'(px.blue) * COEF_BLUE) >> LUMA_SHIFT;
        if (gray_level < thresh_reg)
        begin
            if (col_pos < box_min_col)
                box_min_col = {1'b0, col_pos};
            if (row_pos < box_min_row)
                box_min_row = {1'b0, row_pos};
            if (col_pos > box_max_col)
                box_max_col = col_pos;
            if (row_pos > box_max_row)
                box_max_row = row_pos;
            col_inked = 1'b1;
        end
        if (row_pos >= h_eff - 11'd1)
        begin
            if (!col_inked)
            begin
                if (!prev_col_blank)
                begin
                    found.box_left = box_min_col[9:0];
                    found.box_top = box_min_row[9:0];
                    found.box_width = box_max_col - box_min_col + 11'd1;
                    found.box_height = box_max_row - box_min_row + 11'd1;
                    box_expect.push_back(found);
                    restore_box();
                end
                prev_col_blank = 1'b1;
            end
            else
                prev_col_blank = 1'b0;
            col_inked = 1'b0;
            row_pos = '0;
            if (col_pos >= w_eff - 11'd1)
                restart_image();
            else
                col_pos = col_pos + 10'd1;
        end
        else
            row_pos = row_pos + 10'd1;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] box mismatch: %0s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic queue_pixel(input pixel_t px);
        pixel_backlog.push_back(px);
        pixels_queued++;
    endtask

    function automatic pixel_t shade_pixel(input bit ink);
        pixel_t px;
        int unsigned lvl;
        if ($urandom_range(9) == 0 || thresh_reg == 0 || thresh_reg > 255)
        begin
            px.red = $urandom_range(255);
            px.green = $urandom_range(255);
            px.blue = $urandom_range(255);
            return px;
        end
        lvl = ink ? $urandom_range(thresh_reg - 1, 0) : $urandom_range(255, thresh_reg);
        px = pixel_t'{lvl[7:0], lvl[7:0], lvl[7:0]};
        return px;
    endfunction

    task automatic queue_glyph_columns(input int columns);
        int rows;
        int top;
        int bottom;
        bit inked;
        rows = int'(clamp_dim(height_reg, MAX_ROWS));
        for (int c = 0; c < columns; c++)
        begin
            inked = $urandom_range(99) < 55;
            top = $urandom_range(rows - 1);
            bottom = $urandom_range(rows - 1, top);
            for (int r = 0; r < rows; r++)
                queue_pixel(shade_pixel(inked && r >= top && r <= bottom));
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH: width_reg = data;
            CFG_IMAGE_HEIGHT: height_reg = data;
            CFG_DARK_THRESHOLD: thresh_reg = data[8:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int w, input int h, input int thr);
        write_register(CFG_IMAGE_WIDTH, w[10:0]);
        write_register(CFG_IMAGE_HEIGHT, h[10:0]);
        write_register(CFG_DARK_THRESHOLD, thr[10:0]);
        @(posedge clk);
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pixels_accepted != pixels_queued || box_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!pixel_valid || pixel_taken))
        begin
            if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pixel_valid <= 1'b1;
                pixel <= pixel_backlog.pop_front();
            end
            else
                pixel_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            box_stall <= box_hold || ($urandom_range(99) < recv_idle_pct);
    end

    initial
    begin
        wait (box_hold_request);
        @(posedge clk);
        box_hold = 1'b1;
        repeat (BOX_HOLD_CYCLES) @(posedge clk);
        box_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (box_valid && !box_stall)
            begin
                if (box_expect.size() == 0)
                    report_mismatch($sformatf("unexpected box left %0d top %0d",
                                              box.box_left, box.box_top));
                else
                begin
                    due_box = box_expect.pop_front();
                    if (box.box_left !== due_box.box_left)
                        report_mismatch($sformatf("box_left got %0d want %0d",
                                                  box.box_left, due_box.box_left));
                    if (box.box_top !== due_box.box_top)
                        report_mismatch($sformatf("box_top got %0d want %0d",
                                                  box.box_top, due_box.box_top));
                    if (box.box_width !== due_box.box_width)
                        report_mismatch($sformatf("box_width got %0d want %0d",
                                                  box.box_width, due_box.box_width));
                    if (box.box_height !== due_box.box_height)
                        report_mismatch($sformatf("box_height got %0d want %0d",
                                                  box.box_height, due_box.box_height));
                end
            end
            pixel_taken <= pixel_valid && !pixel_stall;
            if (pixel_valid && !pixel_stall)
            begin
                segment_pixel(pixel);
                pixels_accepted <= pixels_accepted + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        width_reg = WIDTH_RST;
        height_reg = HEIGHT_RST;
        thresh_reg = THRESH_RST;
        restart_image();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 75;
        configure(5, 3, 128);
        // leading blank column
        queue_pixel(pixel_t'{8'd255, 8'd255, 8'd255});
        queue_pixel(pixel_t'{8'd0, 8'd255, 8'd0});
        queue_pixel(pixel_t'{8'd255, 8'd255, 8'd0});
        queue_pixel(pixel_t'{8'd0, 8'd0, 8'd0});
        queue_pixel(pixel_t'{8'd255, 8'd0, 8'd0});
        queue_pixel(pixel_t'{8'd0, 8'd0, 8'd255});
        // blank column closes the glyph, then a repeated blank column
        repeat (6) queue_pixel(pixel_t'{8'd255, 8'd255, 8'd255});
        // glyph on the right edge, dropped at image end
        queue_pixel(pixel_t'{8'd255, 8'd255, 8'd255});
        queue_pixel(pixel_t'{8'd0, 8'd0, 8'd0});
        queue_pixel(pixel_t'{8'd255, 8'd255, 8'd255});
        // next image starts clean
        queue_pixel(pixel_t'{8'd200, 8'd200, 8'd200});
        queue_pixel(pixel_t'{8'd128, 8'd128, 8'd128});
        queue_pixel(pixel_t'{8'd127, 8'd127, 8'd127});
        repeat (3) queue_pixel(pixel_t'{8'd128, 8'd128, 8'd128});
        wait_until_drained();

        configure(16, 8, 128);
        queue_glyph_columns(30);
        wait_until_drained();
        configure(0, 0, 256);
        queue_glyph_columns(20);
        wait_until_drained();
        write_register(CFG_UNUSED_INDEX, 11'h7FF);
        configure(12, 5, 0);
        queue_glyph_columns(12);
        wait_until_drained();

        send_idle_pct = 75;
        recv_idle_pct = 17;
        configure(2047, 1, 200);
        queue_glyph_columns(1024);
        wait_until_drained();
        configure(20, 10, 11'h43C);
        queue_glyph_columns(30);
        wait_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(64, 1, 128);
        box_hold_request = 1'b1;
        for (int i = 0; i < 200; i++)
            queue_pixel(shade_pixel(i % 2 == 0));
        wait_until_drained();
        configure(9, 7, 255);
        queue_glyph_columns(20);
        wait_until_drained();
        configure(4, 2, 511);
        queue_glyph_columns(10);
        wait_until_drained();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
